// ===== hw/rtl/mbfp_pkg.sv =====
// Shared types and constants for the MSB-first bit field packer.
// Used by the controller, the datapath, the top level and the checks; no dependencies.

package mbfp_pkg;

    // Field widths of one input item and one result
    localparam int unsigned ValueW = 64;
    localparam int unsigned WidthW = 7;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned IndexW = 12;
    localparam int unsigned CountW = 13;
    localparam int unsigned BitCntW = 3;

    // Packed beat widths on the stream ports
    localparam int unsigned InTdataW  = 80;
    localparam int unsigned OutTdataW = 24;

    // Bit positions inside the input tdata
    localparam int unsigned InWidthLsb = 64;
    localparam int unsigned InAlignBit = 71;
    localparam int unsigned InStartBit = 72;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic work_done;
    } t_dp_status;

endpackage

// ===== hw/rtl/mbfp_ctrl.sv =====
// Controller of the bit field packer: sequences load and per-byte steps.
// Depends on mbfp_pkg for the state and command/status types.

module mbfp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mbfp_pkg::t_dp_status i_status,
    output mbfp_pkg::t_ctrl_cmd  o_cmd
);

    mbfp_pkg::t_state r_state;
    mbfp_pkg::t_state n_state;

    // Take an item only while idle
    assign o_in_ready = (r_state == mbfp_pkg::S_IDLE);

    // Issue commands and choose the next state
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            mbfp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mbfp_pkg::S_RUN;
                end
            end
            mbfp_pkg::S_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.work_done) begin
                        n_state = mbfp_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = mbfp_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbfp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/mbfp_dp.sv =====
// Datapath of the bit field packer: capacity register, pending byte, byte
// count, field shifter and the output register. Depends on mbfp_pkg.

module mbfp_dp #(
    parameter int unsigned MAX_BYTES = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mbfp_pkg::CountW-1:0]          i_cfg_wr_data,
    input  logic [mbfp_pkg::ValueW-1:0]          i_field_value,
    input  logic [mbfp_pkg::WidthW-1:0]          i_field_width,
    input  logic                                 i_align_first,
    input  logic                                 i_start_new,
    input  mbfp_pkg::t_ctrl_cmd                  i_cmd,
    output mbfp_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mbfp_pkg::ByteW-1:0]           o_out_byte,
    output logic [mbfp_pkg::IndexW-1:0]          o_byte_index,
    output logic                                 o_overflow,
    output logic                                 o_last
);

    // Effective capacity is the written value limited to the smaller of MAX_BYTES and 8191
    localparam int unsigned CapLimit = (MAX_BYTES < 8191) ? MAX_BYTES : 8191;
    localparam int unsigned CapReset = (MAX_BYTES < 4096) ? MAX_BYTES : 4096;

    logic [mbfp_pkg::CountW-1:0]  r_cap;
    logic [mbfp_pkg::ByteW-1:0]   r_pend,  n_pend;
    logic [mbfp_pkg::BitCntW-1:0] r_cnt,   n_cnt;
    logic [mbfp_pkg::CountW-1:0]  r_bd,    n_bd;
    logic [mbfp_pkg::ValueW-1:0]  r_sh,    n_sh;
    logic [mbfp_pkg::WidthW-1:0]  r_rem,   n_rem;
    logic                         r_align, n_align;
    logic                         r_out_valid;
    logic [mbfp_pkg::ByteW-1:0]   r_out_byte,  n_out_byte;
    logic [mbfp_pkg::IndexW-1:0]  r_out_idx,   n_out_idx;
    logic                         r_out_ovf,   n_out_ovf;
    logic                         r_out_last,  n_out_last;

    logic                         res_valid;
    logic                         work_done;
    logic [3:0]                   room;
    logic [3:0]                   take;
    logic [mbfp_pkg::ByteW-1:0]   merged;
    logic                         fills;
    logic [mbfp_pkg::CountW-1:0]  bd_inc;
    logic                         cap_hit;
    logic                         cap_hit_inc;
    logic [mbfp_pkg::WidthW-1:0]  rem_left;
    logic [mbfp_pkg::WidthW-1:0]  load_shift;
    logic                         load_restart_cnt0;

    // Capacity register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= mbfp_pkg::CountW'(CapReset);
        end else if (i_cfg_wr_en) begin
            r_cap <= (i_cfg_wr_data > mbfp_pkg::CountW'(CapLimit))
                   ? mbfp_pkg::CountW'(CapLimit) : i_cfg_wr_data;
        end
    end

    // Step arithmetic: bits that fit in the pending byte this step
    assign room        = 4'd8 - {1'b0, r_cnt};
    assign take        = (r_rem < {3'b000, room}) ? r_rem[3:0] : room;
    assign merged      = r_pend | (r_sh[mbfp_pkg::ValueW-1 -: mbfp_pkg::ByteW] >> r_cnt);
    assign fills       = (({1'b0, r_cnt} + take) == 4'd8);
    assign bd_inc      = r_bd + mbfp_pkg::CountW'(1);
    assign cap_hit     = (r_bd >= r_cap);
    assign cap_hit_inc = (bd_inc >= r_cap);
    assign rem_left    = r_rem - {3'b000, take};

    // Left-align the field so its first bit sits at the top of the shifter
    assign load_shift        = mbfp_pkg::WidthW'(64) - i_field_width;
    assign load_restart_cnt0 = i_start_new || (r_cnt == '0);

    // Next state of the packing registers
    always_comb begin
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_bd        = r_bd;
        n_sh        = r_sh;
        n_rem       = r_rem;
        n_align     = r_align;
        n_out_byte  = r_out_byte;
        n_out_idx   = r_out_idx;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        res_valid   = 1'b0;
        work_done   = 1'b1;

        if (i_cmd.load) begin
            // Restart first, then note whether a pad byte is owed
            if (i_start_new) begin
                n_pend = '0;
                n_cnt  = '0;
                n_bd   = '0;
            end
            n_align = i_align_first && !load_restart_cnt0;
            if (i_field_width <= mbfp_pkg::WidthW'(64)) begin
                n_rem = i_field_width;
                n_sh  = i_field_value << load_shift;
            end else begin
                n_rem = '0;
                n_sh  = '0;
            end
        end else if (i_cmd.step) begin
            if (r_align) begin
                // Pad and emit the partial byte
                res_valid  = 1'b1;
                n_out_byte = r_pend;
                n_out_idx  = r_bd[mbfp_pkg::IndexW-1:0];
                n_out_ovf  = 1'b0;
                n_out_last = !((r_rem != '0) && (cap_hit_inc || (r_rem >= 7'd8)));
                n_pend     = '0;
                n_cnt      = '0;
                n_bd       = bd_inc;
                n_align    = 1'b0;
                work_done  = (r_rem == '0);
            end else if (r_rem == '0) begin
                // Nothing left to write
                work_done = 1'b1;
            end else if (cap_hit) begin
                // Abort the item with an overflow result
                res_valid  = 1'b1;
                n_out_byte = '0;
                n_out_idx  = r_bd[mbfp_pkg::IndexW-1:0];
                n_out_ovf  = 1'b1;
                n_out_last = 1'b1;
                n_rem      = '0;
                work_done  = 1'b1;
            end else begin
                // Move up to a byte's worth of bits into the pending byte
                n_sh      = r_sh << take;
                n_rem     = rem_left;
                work_done = (rem_left == '0);
                if (fills) begin
                    res_valid  = 1'b1;
                    n_out_byte = merged;
                    n_out_idx  = r_bd[mbfp_pkg::IndexW-1:0];
                    n_out_ovf  = 1'b0;
                    n_out_last = !((rem_left != '0) &&
                                   (cap_hit_inc || (rem_left >= 7'd8)));
                    n_pend     = '0;
                    n_cnt      = '0;
                    n_bd       = bd_inc;
                end else begin
                    n_pend = merged;
                    n_cnt  = r_cnt + take[mbfp_pkg::BitCntW-1:0];
                end
            end
        end
    end

    // Packing state and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_cnt   <= '0;
            r_bd    <= '0;
            r_rem   <= '0;
            r_align <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_bd    <= n_bd;
            r_rem   <= n_rem;
            r_align <= n_align;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_out_byte <= n_out_byte;
        r_out_idx  <= n_out_idx;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    // Output register valid: set on a new result, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.work_done = work_done;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_index = r_out_idx;
    assign o_overflow   = r_out_ovf;
    assign o_last       = r_out_last;

endmodule

// ===== hw/rtl/msb_first_bit_field_packer.sv =====
// Top level of the MSB-first bit field packer: stream ports, controller
// and datapath. Depends on mbfp_pkg, mbfp_ctrl and mbfp_dp.

// Packs fields of 0 to 64 bits, first bit into bit 7, into numbered bytes.
// One item is taken at a time: it is loaded, then handled step by step,
// where a step emits the padded partial byte, moves up to a byte of field
// bits into the pending byte, or gives the overflow result. The single
// output register makes each step wait while a beat is stalled.
// Capacity writes take effect at once and belong between items.

module msb_first_bit_field_packer #(
    parameter int unsigned MAX_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Capacity register write
    input  logic                              i_cfg_wr_en,
    input  logic [mbfp_pkg::CountW-1:0]       i_cfg_wr_data,
    // Input items
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // field_value[63:0], field_width[70:64], align_first[71], start_new[72],
    // zero [79:73]
    input  logic [mbfp_pkg::InTdataW-1:0]     i_s_axis_tdata,
    // Result beats
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_byte[7:0], byte_index[19:8], zero [23:20]
    output logic [mbfp_pkg::OutTdataW-1:0]    o_m_axis_tdata,
    // overflow[0]
    output logic                              o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    mbfp_pkg::t_ctrl_cmd  cmd;
    mbfp_pkg::t_dp_status status;

    logic [mbfp_pkg::ByteW-1:0]  out_byte;
    logic [mbfp_pkg::IndexW-1:0] byte_index;

    mbfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbfp_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_field_value (i_s_axis_tdata[mbfp_pkg::ValueW-1:0]),
        .i_field_width (i_s_axis_tdata[mbfp_pkg::InWidthLsb +: mbfp_pkg::WidthW]),
        .i_align_first (i_s_axis_tdata[mbfp_pkg::InAlignBit]),
        .i_start_new   (i_s_axis_tdata[mbfp_pkg::InStartBit]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_byte    (out_byte),
        .o_byte_index  (byte_index),
        .o_overflow    (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast)
    );

    // Pack the result beat
    assign o_m_axis_tdata = {4'b0000, byte_index, out_byte};

endmodule

// ===== hw/rtl/mbfp_chk.sv =====
// Port-level checks for the bit field packer, bound to the top level.
// Depends on mbfp_pkg for port widths.

module mbfp_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [mbfp_pkg::OutTdataW-1:0]  o_m_axis_tdata,
    input logic                            o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
        && $stable(o_m_axis_tlast))
        else $error("stalled result beat changed");

    // An overflow ends the item
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("overflow result without last");

    // An overflow carries no byte
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (o_m_axis_tdata[7:0] == 8'h00))
        else $error("overflow result with a non-zero byte");

    // An accepted item keeps the input closed for at least its first step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready straight after an accepted item");

endmodule

bind msb_first_bit_field_packer mbfp_chk u_mbfp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
